// ===== hdl/shamh_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 message hasher.
// Used by shamh_ctrl, shamh_dp and sha256_message_hash; depends on nothing.
package shamh_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LenStart   = 56;
    localparam int unsigned Rounds     = 64;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] K_ROUND [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_LEN,
        S_LOAD,
        S_ROUND,
        S_FOLD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        BYTE_DATA,
        BYTE_PAD,
        BYTE_ZERO,
        BYTE_LEN
    } t_byte_sel;

    typedef struct packed {
        logic      wr_en;
        t_byte_sel sel;
        logic      add_len;
        logic      load;
        logic      round;
        logic [5:0] rnd;
        logic      fold;
        logic      restart;
        logic [2:0] widx;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_dp_stat;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== hdl/shamh_ctrl.sv =====
// Sequencer of the SHA-256 message hasher: byte intake, padding, rounds, output.
// Depends on shamh_pkg; drives shamh_dp through a command struct.
module shamh_ctrl
    import shamh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_has_byte,
    input  logic       i_is_last,
    input  logic       i_out_ready,
    input  t_dp_stat   i_stat,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output logic [2:0] o_word_index,
    output logic       o_last_word,
    output t_dp_cmd    o_cmd
);

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    logic [5:0] r_rcnt, n_rcnt;
    logic [2:0] r_widx, n_widx;

    logic fill_end;
    logic fill_len;

    assign fill_end = (i_stat.fill == 6'(BlockBytes - 1));
    assign fill_len = (i_stat.fill == 6'(LenStart));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_rcnt  <= '0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_rcnt  <= n_rcnt;
            r_widx  <= n_widx;
        end
    end

    // Next state. A full buffer always detours through LOAD/ROUND/FOLD and
    // comes back to the state held in r_ret.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_rcnt  = r_rcnt;
        n_widx  = r_widx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_has_byte && fill_end) begin
                        n_ret   = i_is_last ? S_PAD80 : S_IDLE;
                        n_state = S_LOAD;
                    end else if (i_is_last) begin
                        n_state = S_PAD80;
                    end
                end
            end
            S_PAD80: begin
                if (fill_end) begin
                    n_ret   = S_PADZ;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_PADZ;
                end
            end
            S_PADZ: begin
                if (fill_len) begin
                    n_state = S_LEN;
                end else if (fill_end) begin
                    n_ret   = S_PADZ;
                    n_state = S_LOAD;
                end
            end
            S_LEN: begin
                if (fill_end) begin
                    n_ret   = S_OUT;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_rcnt  = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_rcnt = r_rcnt + 6'd1;
                if (r_rcnt == 6'(Rounds - 1)) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_state = r_ret;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == 3'd7) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd         = '0;
        o_cmd.sel     = BYTE_DATA;
        o_cmd.rnd     = r_rcnt;
        o_cmd.widx    = r_widx;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_has_byte) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.add_len = 1'b1;
                end
            end
            S_PAD80: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.sel   = BYTE_PAD;
            end
            S_PADZ: begin
                o_cmd.wr_en = !fill_len;
                o_cmd.sel   = BYTE_ZERO;
            end
            S_LEN: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.sel   = BYTE_LEN;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
            end
            S_OUT: begin
                o_out_valid   = 1'b1;
                o_cmd.restart = i_out_ready && (r_widx == 3'd7);
            end
            default: begin
                o_cmd.wr_en = 1'b0;
            end
        endcase
    end

    assign o_word_index = r_widx;
    assign o_last_word  = (r_widx == 3'd7);

endmodule

// ===== hdl/shamh_dp.sv =====
// Datapath of the SHA-256 message hasher: block/schedule window, round
// registers, chaining value and length counter. Depends on shamh_pkg.
module shamh_dp
    import shamh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_data_byte,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic [31:0] o_digest_word
);

    // The block buffer is the schedule window itself: bytes land in their
    // big-endian word slots, and rounds shift the window down by one word.
    logic [31:0] r_win   [16];
    logic [31:0] r_vars  [8];
    logic [31:0] r_chain [8];
    logic [63:0] r_bitlen;
    logic [5:0]  r_fill;

    logic [7:0]  wr_byte;
    logic [7:0]  len_byte;
    logic [31:0] w_next;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    assign len_byte = 8'(r_bitlen >> {~r_fill[2:0], 3'b000});

    always_comb begin
        case (i_cmd.sel)
            BYTE_DATA: wr_byte = i_data_byte;
            BYTE_PAD:  wr_byte = PAD_BYTE;
            BYTE_ZERO: wr_byte = 8'h00;
            BYTE_LEN:  wr_byte = len_byte;
            default:   wr_byte = 8'h00;
        endcase
    end

    assign w_next = small_sigma1(r_win[14]) + r_win[9] + small_sigma0(r_win[1]) + r_win[0];

    assign ch  = (r_vars[4] & r_vars[5]) ^ (~r_vars[4] & r_vars[6]);
    assign maj = (r_vars[0] & r_vars[1]) ^ (r_vars[0] & r_vars[2]) ^ (r_vars[1] & r_vars[2]);
    assign t1  = r_vars[7] + big_sigma1(r_vars[4]) + ch + K_ROUND[i_cmd.rnd] + r_win[0];
    assign t2  = big_sigma0(r_vars[0]) + maj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_win[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= wr_byte;
        end else if (i_cmd.round) begin
            for (int j = 0; j < 15; j++) begin
                r_win[j] <= r_win[j + 1];
            end
            r_win[15] <= w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int j = 0; j < 8; j++) begin
                r_vars[j] <= r_chain[j];
            end
        end else if (i_cmd.round) begin
            r_vars[7] <= r_vars[6];
            r_vars[6] <= r_vars[5];
            r_vars[5] <= r_vars[4];
            r_vars[4] <= r_vars[3] + t1;
            r_vars[3] <= r_vars[2];
            r_vars[2] <= r_vars[1];
            r_vars[1] <= r_vars[0];
            r_vars[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 8; j++) begin
                r_chain[j] <= H_INIT[j];
            end
            r_bitlen <= '0;
            r_fill   <= '0;
        end else if (i_cmd.restart) begin
            for (int j = 0; j < 8; j++) begin
                r_chain[j] <= H_INIT[j];
            end
            r_bitlen <= '0;
            r_fill   <= '0;
        end else begin
            if (i_cmd.fold) begin
                for (int j = 0; j < 8; j++) begin
                    r_chain[j] <= r_chain[j] + r_vars[j];
                end
            end
            if (i_cmd.wr_en) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.add_len) begin
                r_bitlen <= r_bitlen + 64'd8;
            end
        end
    end

    assign o_stat.fill   = r_fill;
    assign o_digest_word = r_chain[i_cmd.widx];

endmodule

// ===== hdl/sha256_message_hash.sv =====
// Top level of the SHA-256 message hasher, at most one message byte per transfer.
// Depends on shamh_pkg, shamh_ctrl and shamh_dp.
//
//  Channel   Handshake                   Payload
//  input     i_in_valid / o_in_ready     i_data_byte, i_has_byte, i_is_last
//  output    o_out_valid / i_out_ready   o_digest_word, o_word_index, o_last_word
//
// A byte that does not complete a block leaves the hasher ready for the next.
// Every full 64-byte block then goes through the shared round unit (load,
// 64 rounds, fold) before the next byte is taken. Padding writes at most one
// byte per cycle and pauses while a full block is compressed, then eight digest transfers follow;
// input is not taken while padding, compressing or sending the digest.
// Reset is synchronous and restores the initial hash value, length and fill.
// Output stalls simply hold the current digest word.
module sha256_message_hash
    import shamh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    shamh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_has_byte   (i_has_byte),
        .i_is_last    (i_is_last),
        .i_out_ready  (i_out_ready),
        .i_stat       (stat),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word),
        .o_cmd        (cmd)
    );

    shamh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_data_byte),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_digest_word (o_digest_word)
    );

endmodule
